FILE: design/stick_radial_dead_zone_core_macros.svh
// assertion helpers for the radial dead zone core
`ifndef STICK_RADIAL_DEAD_ZONE_CORE_MACROS_SVH
`define STICK_RADIAL_DEAD_ZONE_CORE_MACROS_SVH

// same-cycle implication, reset masked
`define SRDZ_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, reset masked
`define SRDZ_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: design/srdz_pkg.sv
package srdz_pkg;

  localparam int OUT_BITS = 16;
  localparam int CFG_BITS = 16;
  localparam int Q_BITS   = 16;

  localparam logic [CFG_BITS-1:0] DEAD_ZONE_RST = 16'd8000;
  localparam logic [CFG_BITS-1:0] MAX_VALUE_RST = 16'd30000;
  localparam logic [OUT_BITS-1:0] FULL_SCALE    = 16'd32767;

  typedef enum logic [0:0] {
    CFG_DEAD_ZONE = 1'b0,
    CFG_MAX_VALUE = 1'b1
  } cfg_idx_t;

  typedef struct packed {
    logic signed [OUT_BITS-1:0] scaled_x;
    logic signed [OUT_BITS-1:0] scaled_y;
    logic                       in_dead_zone;
  } out_t;

endpackage

FILE: design/stick_radial_dead_zone_core.sv
// radial dead zone and rescaling for one analog stick
// input transaction: in_valid/in_ready with in_data = {axis_x, axis_y}, each a
//   SAMPLE_BITS two's complement sample, axis_x in the upper half
// output transaction: out_valid/out_ready with out_data (scaled_x, scaled_y,
//   in_dead_zone); one output per input, in order
// config: cfg_we with cfg_index (0 dead zone, 1 max radius) and cfg_wdata, must be
//   written only while the pipeline is empty; the block itself does not enforce this
// pipeline: magnitude, squares, sum, the square root stages with one root bit
//   per stage, fraction terms, products, the divider stages with one quotient bit per stage, output
// throughput: one transaction per cycle; the whole pipe advances whenever the
//   output stage is empty or being taken
// when out_ready is low with a result waiting, the pipe freezes, in_ready drops
//   and nothing is lost or repeated
// reset: synchronous active-low rst_n clears all stage valids and loads the
//   dead zone 8000 and max radius 30000; no clearing pass is needed
module stick_radial_dead_zone_core #(
  parameter int SAMPLE_BITS = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [2*SAMPLE_BITS-1:0]     in_data,
  output logic                         out_valid,
  input  logic                         out_ready,
  output srdz_pkg::out_t               out_data,
  input  logic                         cfg_we,
  input  logic [0:0]                   cfg_index,
  input  logic [srdz_pkg::CFG_BITS-1:0] cfg_wdata
);

  localparam int SB   = SAMPLE_BITS;
  localparam int CW   = srdz_pkg::CFG_BITS;
  localparam int QB   = srdz_pkg::Q_BITS;
  localparam int SQW  = 2 * SB;
  localparam int RMW  = SB + 2;
  localparam int LW   = ((SB > CW) ? SB : CW) + 1;
  localparam int PW   = SB + CW;
  localparam int DW   = SB + CW;
  localparam int IDX_SQ = 3;
  localparam int IDX_D  = IDX_SQ + SB;
  localparam int IDX_E  = IDX_D + 1;
  localparam int IDX_V  = IDX_E + 1;
  localparam int NST    = IDX_V + QB + 1;

  typedef struct packed {
    logic signed [SB-1:0] axis_x;
    logic signed [SB-1:0] axis_y;
  } in_t;

  in_t in_s;
  assign in_s = in_t'(in_data);

  logic [CW-1:0] dz_r, mv_r;
  logic [NST-1:0] vld_r;
  logic adv;

  assign adv       = out_ready || !vld_r[NST-1];
  assign in_ready  = adv;
  assign out_valid = vld_r[NST-1];

  // stage a: magnitude and sign
  logic [SB-1:0] a_mx_r, a_my_r;
  logic a_nx_r, a_ny_r;
  // stage b: squares
  logic [SQW-1:0] b_sx_r, b_sy_r;
  logic [SB-1:0] b_mx_r, b_my_r;
  logic b_nx_r, b_ny_r;
  // stage c: sum
  logic [SQW-1:0] c_sum_r;
  logic [SB-1:0] c_mx_r, c_my_r;
  logic c_nx_r, c_ny_r;
  // root stages
  logic [RMW-1:0] q_rem_r [SB];
  logic [SB-1:0]  q_root_r [SB];
  logic [SQW-1:0] q_rest_r [SB];
  logic [SB-1:0]  q_mx_r [SB];
  logic [SB-1:0]  q_my_r [SB];
  logic           q_nx_r [SB];
  logic           q_ny_r [SB];
  logic [RMW-1:0] q_rem_nxt [SB];
  logic [SB-1:0]  q_root_nxt [SB];
  logic [SQW-1:0] q_rest_nxt [SB];
  // stage d: fraction terms
  logic d_flag_r, d_zero_r;
  logic [CW-1:0] d_num_r, d_den_r;
  logic [SB-1:0] d_len_r, d_mx_r, d_my_r;
  logic d_nx_r, d_ny_r;
  logic d_flag_nxt, d_zero_nxt;
  logic [CW-1:0] d_num_nxt, d_den_nxt;
  // stage e: products
  logic [PW-1:0] e_px_r, e_py_r;
  logic [DW-1:0] e_dv_r;
  logic e_flag_r, e_zero_r, e_nx_r, e_ny_r;
  // divider stages
  logic [DW-1:0] v_rx_r [QB];
  logic [DW-1:0] v_ry_r [QB];
  logic [QB-1:0] v_qx_r [QB];
  logic [QB-1:0] v_qy_r [QB];
  logic [DW-1:0] v_dv_r [QB];
  logic v_flag_r [QB];
  logic v_zero_r [QB];
  logic v_nx_r [QB];
  logic v_ny_r [QB];
  logic [DW-1:0] v_rx_nxt [QB];
  logic [DW-1:0] v_ry_nxt [QB];
  logic [QB-1:0] v_qx_nxt [QB];
  logic [QB-1:0] v_qy_nxt [QB];
  // output
  srdz_pkg::out_t out_r, out_nxt;

  assign out_data = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dz_r <= srdz_pkg::DEAD_ZONE_RST;
      mv_r <= srdz_pkg::MAX_VALUE_RST;
    end else if (cfg_we) begin
      case (srdz_pkg::cfg_idx_t'(cfg_index))
        srdz_pkg::CFG_DEAD_ZONE: dz_r <= cfg_wdata;
        srdz_pkg::CFG_MAX_VALUE: mv_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[NST-2:0], in_valid};
    end
  end

  // integer square root, one result bit per stage
  always_comb begin
    logic [RMW-1:0] rem_i, r2, trial;
    logic [SB-1:0]  root_i;
    logic [SQW-1:0] rest_i;
    for (int k = 0; k < SB; k++) begin
      if (k == 0) begin
        rem_i  = '0;
        root_i = '0;
        rest_i = c_sum_r;
      end else begin
        rem_i  = q_rem_r[k-1];
        root_i = q_root_r[k-1];
        rest_i = q_rest_r[k-1];
      end
      r2    = {rem_i[RMW-3:0], rest_i[SQW-1:SQW-2]};
      trial = {root_i, 2'b01};
      if (r2 >= trial) begin
        q_rem_nxt[k]  = r2 - trial;
        q_root_nxt[k] = {root_i[SB-2:0], 1'b1};
      end else begin
        q_rem_nxt[k]  = r2;
        q_root_nxt[k] = {root_i[SB-2:0], 1'b0};
      end
      q_rest_nxt[k] = {rest_i[SQW-3:0], 2'b00};
    end
  end

  always_comb begin
    logic [LW-1:0] len_w, dz_w, mv_w, num_w, den_w;
    len_w = {{(LW-SB){1'b0}}, q_root_r[SB-1]};
    dz_w  = {{(LW-CW){1'b0}}, dz_r};
    mv_w  = {{(LW-CW){1'b0}}, mv_r};
    num_w = len_w - dz_w;
    den_w = mv_w - dz_w;
    d_flag_nxt = len_w < dz_w;
    d_zero_nxt = d_flag_nxt || (q_root_r[SB-1] == '0);
    if ((mv_w <= dz_w) || (num_w >= den_w)) begin
      d_num_nxt = CW'(1);
      d_den_nxt = CW'(1);
    end else begin
      d_num_nxt = num_w[CW-1:0];
      d_den_nxt = den_w[CW-1:0];
    end
  end

  // restoring division, one quotient bit per stage
  always_comb begin
    logic [DW-1:0] rx_i, ry_i, dv_i;
    logic [QB-1:0] qx_i, qy_i;
    logic          bx, by;
    logic [DW:0]   tx, ty;
    for (int k = 0; k < QB; k++) begin
      if (k == 0) begin
        rx_i = {1'b0, e_px_r[PW-1:1]};
        ry_i = {1'b0, e_py_r[PW-1:1]};
        qx_i = '0;
        qy_i = '0;
        dv_i = e_dv_r;
        bx   = e_px_r[0];
        by   = e_py_r[0];
      end else begin
        rx_i = v_rx_r[k-1];
        ry_i = v_ry_r[k-1];
        qx_i = v_qx_r[k-1];
        qy_i = v_qy_r[k-1];
        dv_i = v_dv_r[k-1];
        bx   = 1'b0;
        by   = 1'b0;
      end
      tx = {rx_i, bx};
      ty = {ry_i, by};
      if (tx >= {1'b0, dv_i}) begin
        v_rx_nxt[k] = DW'(tx - {1'b0, dv_i});
        v_qx_nxt[k] = {qx_i[QB-2:0], 1'b1};
      end else begin
        v_rx_nxt[k] = tx[DW-1:0];
        v_qx_nxt[k] = {qx_i[QB-2:0], 1'b0};
      end
      if (ty >= {1'b0, dv_i}) begin
        v_ry_nxt[k] = DW'(ty - {1'b0, dv_i});
        v_qy_nxt[k] = {qy_i[QB-2:0], 1'b1};
      end else begin
        v_ry_nxt[k] = ty[DW-1:0];
        v_qy_nxt[k] = {qy_i[QB-2:0], 1'b0};
      end
    end
  end

  always_comb begin
    logic [QB-1:0] qx, qy, sx, sy;
    qx = v_qx_r[QB-1];
    qy = v_qy_r[QB-1];
    sx = qx[QB-1] ? srdz_pkg::FULL_SCALE : qx;
    sy = qy[QB-1] ? srdz_pkg::FULL_SCALE : qy;
    if (v_zero_r[QB-1]) begin
      out_nxt.scaled_x = '0;
      out_nxt.scaled_y = '0;
    end else begin
      out_nxt.scaled_x = v_nx_r[QB-1] ? QB'(-sx) : sx;
      out_nxt.scaled_y = v_ny_r[QB-1] ? QB'(-sy) : sy;
    end
    out_nxt.in_dead_zone = v_flag_r[QB-1];
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_nx_r <= in_s.axis_x[SB-1];
      a_ny_r <= in_s.axis_y[SB-1];
      a_mx_r <= in_s.axis_x[SB-1] ? SB'(~in_s.axis_x + 1'b1) : in_s.axis_x;
      a_my_r <= in_s.axis_y[SB-1] ? SB'(~in_s.axis_y + 1'b1) : in_s.axis_y;

      b_sx_r <= a_mx_r * a_mx_r;
      b_sy_r <= a_my_r * a_my_r;
      b_mx_r <= a_mx_r;
      b_my_r <= a_my_r;
      b_nx_r <= a_nx_r;
      b_ny_r <= a_ny_r;

      c_sum_r <= b_sx_r + b_sy_r;
      c_mx_r  <= b_mx_r;
      c_my_r  <= b_my_r;
      c_nx_r  <= b_nx_r;
      c_ny_r  <= b_ny_r;

      for (int k = 0; k < SB; k++) begin
        q_rem_r[k]  <= q_rem_nxt[k];
        q_root_r[k] <= q_root_nxt[k];
        q_rest_r[k] <= q_rest_nxt[k];
        if (k == 0) begin
          q_mx_r[k] <= c_mx_r;
          q_my_r[k] <= c_my_r;
          q_nx_r[k] <= c_nx_r;
          q_ny_r[k] <= c_ny_r;
        end else begin
          q_mx_r[k] <= q_mx_r[k-1];
          q_my_r[k] <= q_my_r[k-1];
          q_nx_r[k] <= q_nx_r[k-1];
          q_ny_r[k] <= q_ny_r[k-1];
        end
      end

      d_flag_r <= d_flag_nxt;
      d_zero_r <= d_zero_nxt;
      d_num_r  <= d_num_nxt;
      d_den_r  <= d_den_nxt;
      d_len_r  <= q_root_r[SB-1];
      d_mx_r   <= q_mx_r[SB-1];
      d_my_r   <= q_my_r[SB-1];
      d_nx_r   <= q_nx_r[SB-1];
      d_ny_r   <= q_ny_r[SB-1];

      e_px_r   <= d_mx_r * d_num_r;
      e_py_r   <= d_my_r * d_num_r;
      e_dv_r   <= d_den_r * d_len_r;
      e_flag_r <= d_flag_r;
      e_zero_r <= d_zero_r;
      e_nx_r   <= d_nx_r;
      e_ny_r   <= d_ny_r;

      for (int k = 0; k < QB; k++) begin
        v_rx_r[k] <= v_rx_nxt[k];
        v_ry_r[k] <= v_ry_nxt[k];
        v_qx_r[k] <= v_qx_nxt[k];
        v_qy_r[k] <= v_qy_nxt[k];
        if (k == 0) begin
          v_dv_r[k]   <= e_dv_r;
          v_flag_r[k] <= e_flag_r;
          v_zero_r[k] <= e_zero_r;
          v_nx_r[k]   <= e_nx_r;
          v_ny_r[k]   <= e_ny_r;
        end else begin
          v_dv_r[k]   <= v_dv_r[k-1];
          v_flag_r[k] <= v_flag_r[k-1];
          v_zero_r[k] <= v_zero_r[k-1];
          v_nx_r[k]   <= v_nx_r[k-1];
          v_ny_r[k]   <= v_ny_r[k-1];
        end
      end

      out_r <= out_nxt;
    end
  end

endmodule

FILE: design/srdz_checker.sv
`include "stick_radial_dead_zone_core_macros.svh"

module srdz_checker (
  input logic           clk,
  input logic           rst_n,
  input logic           in_ready,
  input logic           out_valid,
  input logic           out_ready,
  input srdz_pkg::out_t out_data
);

  `SRDZ_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data), "output transaction changed while stalled")
  `SRDZ_ASSERT_IMP(a_no_block, out_ready, in_ready, "input blocked while receiver ready")
  `SRDZ_ASSERT_IMP(a_dz_zero, out_valid && out_data.in_dead_zone, (out_data.scaled_x == 16'sd0) && (out_data.scaled_y == 16'sd0), "dead zone result not zero")
  `SRDZ_ASSERT_IMP(a_sat, out_valid, (out_data.scaled_x != 16'sh8000) && (out_data.scaled_y != 16'sh8000), "result outside full scale")

endmodule

bind stick_radial_dead_zone_core srdz_checker u_srdz_checker (.*);

FILE: tb/stick_radial_dead_zone_core_tb.sv
`timescale 1ns / 100ps

module stick_radial_dead_zone_core_tb;

  localparam int SB = 16;
  localparam int LAT = SB + 21;
  localparam int WD_LIMIT = 20000;
  localparam int N_RANDOM = 1620;

  typedef struct packed {
    logic signed [SB-1:0] axis_x;
    logic signed [SB-1:0] axis_y;
  } stick_in_t;

  typedef struct {
    logic signed [SB-1:0] ax;
    logic signed [SB-1:0] ay;
    logic                 known;
    srdz_pkg::out_t       res;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  stick_in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  srdz_pkg::out_t out_data;
  logic cfg_we = 1'b0;
  logic [0:0] cfg_index = srdz_pkg::CFG_DEAD_ZONE;
  logic [srdz_pkg::CFG_BITS-1:0] cfg_wdata = '0;

  logic [srdz_pkg::CFG_BITS-1:0] dz_shadow;
  logic [srdz_pkg::CFG_BITS-1:0] max_shadow;
  srdz_pkg::out_t scaled_q[$];
  int err_cnt = 0;
  int idle_cycles = 0;
  bit hold_off = 1'b0;
  bit rx_random = 1'b0;

  stick_radial_dead_zone_core #(.SAMPLE_BITS(SB)) u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic longint unsigned isqrt(longint unsigned v);
    longint unsigned root;
    longint unsigned b;
    root = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= root + b) begin
        v = v - (root + b);
        root = (root >> 1) + b;
      end else begin
        root = root >> 1;
      end
      b = b >> 2;
    end
    return root;
  endfunction

  function automatic logic signed [15:0] scale_comp(logic signed [SB-1:0] s,
      longint unsigned num, longint unsigned den, longint unsigned len);
    longint unsigned mag;
    longint unsigned q;
    mag = (s < 0) ? longint'(-longint'(s)) : longint'(s);
    q = (mag * num * 32768) / (den * len);
    if (q > 32767) q = 32767;
    return (s < 0) ? -16'(q) : 16'(q);
  endfunction

  function automatic srdz_pkg::out_t predict_scaled(stick_in_t v);
    srdz_pkg::out_t r;
    longint signed sx;
    longint signed sy;
    longint unsigned len;
    longint unsigned num;
    longint unsigned den;
    r = '0;
    sx = v.axis_x;
    sy = v.axis_y;
    len = isqrt(longint'(sx * sx + sy * sy));
    if (len < dz_shadow) begin
      r.in_dead_zone = 1'b1;
      return r;
    end
    if (len == 0) return r;
    num = len - dz_shadow;
    if (max_shadow <= dz_shadow) begin
      num = 1;
      den = 1;
    end else begin
      den = max_shadow - dz_shadow;
      if (num >= den) begin
        num = 1;
        den = 1;
      end
    end
    r.scaled_x = scale_comp(v.axis_x, num, den, len);
    r.scaled_y = scale_comp(v.axis_y, num, den, len);
    return r;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    err_cnt++;
  endtask

  task automatic send_pair(logic signed [SB-1:0] ax, logic signed [SB-1:0] ay,
      bit gaps);
    stick_in_t v;
    int g;
    v.axis_x = ax;
    v.axis_y = ay;
    if (gaps) begin
      g = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
      if ($urandom_range(0, 3) == 0) g = 0;
      if (g > 0) begin
        in_valid <= 1'b0;
        repeat (g) @(posedge clk);
      end
    end
    scaled_q.push_back(predict_scaled(v));
    in_valid <= 1'b1;
    in_data <= v;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic write_cfg_pair(logic [srdz_pkg::CFG_BITS-1:0] dz,
      logic [srdz_pkg::CFG_BITS-1:0] mv);
    cfg_we <= 1'b1;
    cfg_index <= srdz_pkg::CFG_DEAD_ZONE;
    cfg_wdata <= dz;
    @(posedge clk);
    cfg_index <= srdz_pkg::CFG_MAX_VALUE;
    cfg_wdata <= mv;
    @(posedge clk);
    cfg_we <= 1'b0;
    dz_shadow = dz;
    max_shadow = mv;
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    while (scaled_q.size() != 0) @(posedge clk);
    repeat (LAT + 4) @(posedge clk);
  endtask

  function automatic logic signed [SB-1:0] rand_axis();
    case ($urandom_range(0, 5))
      0: return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
      1: return $signed(16'($urandom_range(0, 200))) - 16'sd100;
      default: return 16'($urandom);
    endcase
  endfunction

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (scaled_q.size() == 0) begin
          report_mismatch("unexpected transaction", 0, 0);
        end else begin
          if (out_data.scaled_x !== scaled_q[0].scaled_x)
            report_mismatch("scaled_x", out_data.scaled_x, scaled_q[0].scaled_x);
          if (out_data.scaled_y !== scaled_q[0].scaled_y)
            report_mismatch("scaled_y", out_data.scaled_y, scaled_q[0].scaled_y);
          if (out_data.in_dead_zone !== scaled_q[0].in_dead_zone)
            report_mismatch("in_dead_zone", out_data.in_dead_zone,
                            scaled_q[0].in_dead_zone);
          void'(scaled_q.pop_front());
        end
      end
    end
  end

  always @(posedge clk) begin
    if (hold_off) begin
      out_ready <= 1'b0;
    end else if (!rx_random) begin
      out_ready <= 1'b1;
    end else if ($urandom_range(0, 99) < 3) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 3) != 0);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WD_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    dir_row_t rows[$];
    dir_row_t r;
    srdz_pkg::out_t z;
    int k;
    dz_shadow = srdz_pkg::DEAD_ZONE_RST;
    max_shadow = srdz_pkg::MAX_VALUE_RST;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    z = '0;
    r.known = 1'b1; r.res = z; r.res.in_dead_zone = 1'b1;
    r.ax = 0; r.ay = 0; rows.push_back(r);
    r.ax = 100; r.ay = -100; rows.push_back(r);
    r.res = z; r.res.scaled_x = 16'sd32767;
    r.ax = 16'sh7fff; r.ay = 0; rows.push_back(r);
    r.res = z; r.res.scaled_x = -16'sd32767;
    r.ax = 16'sh8000; r.ay = 0; rows.push_back(r);
    r.res = z; r.res.scaled_y = 16'sd32767;
    r.ax = 0; r.ay = 16'sh7fff; rows.push_back(r);
    r.res = z; r.res.scaled_y = -16'sd32767;
    r.ax = 0; r.ay = 16'sh8000; rows.push_back(r);
    r.known = 1'b0;
    r.ax = 16'sh8000; r.ay = 16'sh8000; rows.push_back(r);
    r.ax = 16'sh7fff; r.ay = 16'sh8000; rows.push_back(r);
    r.ax = 8000; r.ay = 0; rows.push_back(r);
    r.ax = 7999; r.ay = 0; rows.push_back(r);
    r.ax = 12000; r.ay = -9000; rows.push_back(r);
    r.ax = -20000; r.ay = 15000; rows.push_back(r);
    r.ax = 30000; r.ay = 0; rows.push_back(r);
    r.ax = -1; r.ay = 1; rows.push_back(r);

    rx_random = 1'b0;
    foreach (rows[i]) begin
      if (rows[i].known) begin
        scaled_q.push_back(rows[i].res);
        in_valid <= 1'b1;
        in_data <= {rows[i].ax, rows[i].ay};
        do @(posedge clk); while (!in_ready);
      end else begin
        send_pair(rows[i].ax, rows[i].ay, 1'b0);
      end
    end
    drain();

    // zero dead zone, zero vector
    write_cfg_pair(16'd0, 16'd46341);
    send_pair(0, 0, 1'b0);
    send_pair(1, 0, 1'b0);
    send_pair(16'sh8000, 16'sh8000, 1'b0);
    drain();
    // max not above dead zone
    write_cfg_pair(16'd5000, 16'd5000);
    send_pair(5000, 0, 1'b0);
    send_pair(3000, 4000, 1'b0);
    send_pair(-3000, 3999, 1'b0);
    drain();

    rx_random = 1'b1;
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: write_cfg_pair(srdz_pkg::DEAD_ZONE_RST, srdz_pkg::MAX_VALUE_RST);
        1: write_cfg_pair(16'd0, 16'd0);
        2: write_cfg_pair(16'd46341, 16'd46341);
        3: write_cfg_pair(16'd0, 16'd46341);
        4: write_cfg_pair(16'd40000, 16'd1000);
        default: write_cfg_pair(16'($urandom_range(0, 46341)),
                                16'($urandom_range(0, 46341)));
      endcase
      if (ph == 0) begin
        fork
          begin
            hold_off = 1'b1;
            k = 0;
            while (k < 200) begin
              @(posedge clk);
              k++;
            end
            hold_off = 1'b0;
          end
          for (int n = 0; n < 150; n++) send_pair(rand_axis(), rand_axis(), 1'b0);
        join
      end
      for (int n = 0; n < N_RANDOM / 6; n++) send_pair(rand_axis(), rand_axis(), 1'b1);
      drain();
    end

    if (err_cnt == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
